// ----- rtl/tdpt_pkg.sv -----
package tdpt_pkg;

    // Default width of the tested value
    localparam int DEF_VALUE_BITS = 31;

    // Microprogram counter width and size
    localparam int UPC_BITS = 4;

    typedef logic [UPC_BITS-1:0] upc_t;

    // Datapath operations, one per control word
    typedef enum logic [2:0] {
        OP_NOP        = 3'd0,
        OP_ACCEPT     = 3'd1,
        OP_SQRT_STEP  = 3'd2,
        OP_DIV_INIT   = 3'd3,
        OP_DIV_STEP   = 3'd4,
        OP_NEXT_D     = 3'd5,
        OP_EMIT_COMP  = 3'd6,
        OP_EMIT_PRIME = 3'd7
    } uop_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_ITEM  = 3'd2,
        C_LT_TWO   = 3'd3,
        C_CNT_NZ   = 3'd4,
        C_D_GT_E   = 3'd5,
        C_REM_NZ   = 3'd6,
        C_OUT_FULL = 3'd7
    } ucond_t;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        upc_t   target;
    } uword_t;

    // Flags from the datapath to the sequencer
    typedef struct packed {
        logic lt_two;
        logic cnt_nz;
        logic d_gt_e;
        logic rem_nz;
    } dp_status_t;

    // Program addresses
    localparam upc_t L_IDLE      = 4'd0;
    localparam upc_t L_SQRT      = 4'd2;
    localparam upc_t L_TRY       = 4'd4;
    localparam upc_t L_DIV       = 4'd5;
    localparam upc_t L_NOT_PRIME = 4'd7;
    localparam upc_t L_PRIME     = 4'd9;

    // Microprogram: take the jump when the condition holds, else fall through
    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: L_IDLE};
        case (addr)
            4'd0:  w = '{op: OP_ACCEPT,     cond: C_NO_ITEM,  target: L_IDLE};
            4'd1:  w = '{op: OP_NOP,        cond: C_LT_TWO,   target: L_NOT_PRIME};
            4'd2:  w = '{op: OP_SQRT_STEP,  cond: C_CNT_NZ,   target: L_SQRT};
            4'd3:  w = '{op: OP_DIV_INIT,   cond: C_NEVER,    target: L_IDLE};
            4'd4:  w = '{op: OP_NOP,        cond: C_D_GT_E,   target: L_PRIME};
            4'd5:  w = '{op: OP_DIV_STEP,   cond: C_CNT_NZ,   target: L_DIV};
            4'd6:  w = '{op: OP_NEXT_D,     cond: C_REM_NZ,   target: L_TRY};
            4'd7:  w = '{op: OP_EMIT_COMP,  cond: C_OUT_FULL, target: L_NOT_PRIME};
            4'd8:  w = '{op: OP_NOP,        cond: C_ALWAYS,   target: L_IDLE};
            4'd9:  w = '{op: OP_EMIT_PRIME, cond: C_OUT_FULL, target: L_PRIME};
            4'd10: w = '{op: OP_NOP,        cond: C_ALWAYS,   target: L_IDLE};
            default: w = '{op: OP_NOP,      cond: C_ALWAYS,   target: L_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/tdpt_if.sv -----
interface tdpt_in_if
    import tdpt_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] candidate_value;

    modport source (output valid, output candidate_value, input ready);
    modport sink   (input valid, input candidate_value, output ready);
endinterface

interface tdpt_out_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

// ----- rtl/tdpt_seq.sv -----
module tdpt_seq
    import tdpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       out_full,
    input  dp_status_t status,
    output uop_t       op
);

    upc_t   pc_reg;
    upc_t   pc_next;
    uword_t word;
    logic   take;

    assign word = ucode_rom(pc_reg);
    assign op   = word.op;

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_ITEM:  take = !item_valid;
            C_LT_TWO:   take = status.lt_two;
            C_CNT_NZ:   take = status.cnt_nz;
            C_D_GT_E:   take = status.d_gt_e;
            C_REM_NZ:   take = status.rem_nz;
            C_OUT_FULL: take = out_full;
            default:    take = 1'b0;
        endcase
        pc_next = take ? word.target : upc_t'(pc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= L_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- rtl/tdpt_datapath.sv -----
module tdpt_datapath
    import tdpt_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                  clk,
    input  uop_t                  op,
    input  logic                  item_valid,
    input  logic [VALUE_BITS-1:0] candidate_value,
    output dp_status_t            status
);

    localparam int RB = (VALUE_BITS + 1) / 2;   // root bits
    localparam int SW = 2 * RB;                 // feed shifter width
    localparam int CW = $clog2(VALUE_BITS);     // step counter width

    logic [VALUE_BITS-1:0] n_reg;
    logic [SW-1:0]         sh_reg,   sh_next;
    logic [RB+1:0]         rem_reg,  rem_next;
    logic [RB-1:0]         root_reg, root_next;
    logic [RB:0]           d_reg,    d_next;
    logic [CW-1:0]         cnt_reg,  cnt_next;

    logic [RB+3:0] sq_rem;
    logic [RB+3:0] sq_trial;
    logic [RB+1:0] dv_rem;
    logic [RB+1:0] dv_d;

    // One digit pair of the square root, one bit of the remainder
    assign sq_rem   = {rem_reg, sh_reg[SW-1 -: 2]};
    assign sq_trial = (RB+4)'({root_reg, 2'b01});
    assign dv_rem   = {rem_reg[RB:0], sh_reg[SW-1]};
    assign dv_d     = (RB+2)'(d_reg);

    assign status.lt_two = (n_reg < VALUE_BITS'(2));
    assign status.cnt_nz = (cnt_reg != '0);
    assign status.d_gt_e = (d_reg > (RB+1)'(root_reg));
    assign status.rem_nz = (rem_reg != '0);

    always_comb
    begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        unique case (op)
            OP_ACCEPT:
            begin
                sh_next   = SW'(candidate_value);
                rem_next  = '0;
                root_next = '0;
                cnt_next  = CW'(RB - 1);
            end
            OP_SQRT_STEP:
            begin
                sh_next  = sh_reg << 2;
                cnt_next = cnt_reg - 1'b1;
                if (sq_rem >= sq_trial)
                begin
                    rem_next  = (RB+2)'(sq_rem - sq_trial);
                    root_next = {root_reg[RB-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = (RB+2)'(sq_rem);
                    root_next = {root_reg[RB-2:0], 1'b0};
                end
            end
            OP_DIV_INIT, OP_NEXT_D:
            begin
                sh_next  = SW'(n_reg) << (SW - VALUE_BITS);
                rem_next = '0;
                cnt_next = CW'(VALUE_BITS - 1);
                d_next   = (op == OP_DIV_INIT) ? (RB+1)'(2) : d_reg + 1'b1;
            end
            OP_DIV_STEP:
            begin
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                rem_next = (dv_rem >= dv_d) ? dv_rem - dv_d : dv_rem;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_ACCEPT && item_valid)
        begin
            n_reg <= candidate_value;
        end
        sh_reg   <= (op == OP_ACCEPT && !item_valid) ? sh_reg : sh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        d_reg    <= d_next;
        cnt_reg  <= cnt_next;
    end

endmodule

// ----- rtl/trial_division_prime_test_unit.sv -----
// Channel   Dir  Payload                       Handshake
// in_ch     in   candidate_value[VALUE_BITS]   valid / ready
// out_ch    out  is_prime                      valid / ready
//
// Per item: the square root takes one root bit per step, then each divisor
// tried runs the shared remainder loop, which takes one bit per cycle; the
// worst case at 31 bits is near 46340 divisors tried.
// Reset clears the microprogram counter and the output valid flag.
// The verdict waits in the output register; the sequencer stalls only to wait
// for an item, or when a new verdict is ready and the old one is not taken.
module trial_division_prime_test_unit
    import tdpt_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    tdpt_in_if.sink    in_ch,
    tdpt_out_if.source out_ch
);

    uop_t       op;
    dp_status_t status;
    logic       out_valid_reg, out_valid_next;
    logic       is_prime_reg,  is_prime_next;
    logic       emit;

    // Take an item only at the accept step of the program
    assign in_ch.ready = (op == OP_ACCEPT);

    tdpt_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_ch.valid),
        .out_full   (out_valid_reg),
        .status     (status),
        .op         (op)
    );

    tdpt_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk             (clk),
        .op              (op),
        .item_valid      (in_ch.valid),
        .candidate_value (in_ch.candidate_value),
        .status          (status)
    );

    // Load the verdict when the output register is free; the program loops
    // on the emit step until then
    assign emit = ((op == OP_EMIT_PRIME) || (op == OP_EMIT_COMP)) && !out_valid_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            is_prime_next  = (op == OP_EMIT_PRIME);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_prime_reg <= is_prime_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.is_prime = is_prime_reg;

endmodule

// ----- verif/trial_division_prime_test_unit_test.sv -----
`timescale 1ns / 1ps

module trial_division_prime_test_unit_test;
    import tdpt_pkg::*;

    localparam int VALUE_BITS = DEF_VALUE_BITS;

    // Largest legal value; it happens to be prime (2^31 - 1).
    localparam int unsigned VALUE_MAX = (32'd1 << VALUE_BITS) - 1;

    // Slowest item is a prime near the top of the range: about 46340 divisors,
    // each one run through the remainder loop. Allow a wide margin for output
    // stalls on top of that before declaring the block hung.
    localparam int unsigned IDLE_LIMIT = 8_000_000;

    // Cycles to linger after the last verdict to catch stray output items.
    localparam int TAIL_CYCLES = 60;

    localparam int RANDOM_ITEMS = 82;

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct {
        value_t value;
        bit     prime;
    } verdict_t;

    logic clk;
    logic rst_n;

    tdpt_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
    tdpt_out_if                           out_ch ();

    trial_division_prime_test_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Values still to be offered, in order, and verdicts owed by the block.
    value_t      values_to_send [$];
    verdict_t    verdicts_due [$];
    verdict_t    oldest_verdict;
    verdict_t    owed_verdict;

    int          items_total;
    int          items_taken = 0;
    int          mismatches = 0;
    int unsigned idle_cycles = 0;

    // Driver-side and sink-side pacing state.
    int unsigned send_gap;
    int unsigned send_calm;
    int unsigned take_stall;
    int unsigned take_calm;

    int          i;
    int unsigned pick;
    int unsigned factor;
    int unsigned raw_value;

    // Predict primality by plain trial division: try every d with d*d <= n.
    // Widen to 64 bits so d*d never wraps near the top of the range.
    function automatic bit trial_divide_verdict(input value_t n);
        longint unsigned num;
        longint unsigned d;
        num = n;
        if (num < 2)
            return 1'b0;
        for (d = 2; d * d <= num; d++)
        begin
            if (num % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Pick an idle stretch: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    always #1 clk = ~clk;

    // Drive the input channel. Hold an offered item until the block takes it,
    // then either idle for the chosen gap or present the next pending value.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid           <= 1'b0;
            in_ch.candidate_value <= '0;
            send_gap              <= 0;
            send_calm             <= 0;
        end
        else
        begin
            // Record the verdict owed for an item taken at this edge.
            if (in_ch.valid && in_ch.ready)
            begin
                owed_verdict.value = in_ch.candidate_value;
                owed_verdict.prime = trial_divide_verdict(in_ch.candidate_value);
                verdicts_due.insert(verdicts_due.size(), owed_verdict);
                items_taken++;
            end
            // Only touch the channel once the current item (if any) is gone.
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    in_ch.valid <= 1'b0;
                    send_gap    <= send_gap - 1;
                end
                else if (values_to_send.size() != 0)
                begin
                    in_ch.valid           <= 1'b1;
                    in_ch.candidate_value <= values_to_send.pop_front();
                    // In a calm stretch, send back to back; otherwise draw a gap
                    // and occasionally start a new calm stretch.
                    if (send_calm != 0)
                    begin
                        send_gap  <= 0;
                        send_calm <= send_calm - 1;
                    end
                    else
                    begin
                        send_gap  <= pick_gap();
                        send_calm <= ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : 0;
                    end
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor the output channel: compare each verdict against the oldest one
    // owed, and throttle ready with random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            take_stall   <= 0;
            take_calm    <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("is_prime: no verdict expected, got %0d", out_ch.is_prime);
                    mismatches++;
                end
                else
                begin
                    oldest_verdict = verdicts_due.pop_front();
                    if (out_ch.is_prime !== oldest_verdict.prime)
                    begin
                        $error("is_prime for %0d: expected %0d, got %0b",
                               oldest_verdict.value, oldest_verdict.prime, out_ch.is_prime);
                        mismatches++;
                    end
                end
            end
            if (take_stall != 0)
            begin
                out_ch.ready <= 1'b0;
                take_stall   <= take_stall - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (take_calm != 0)
                    take_calm <= take_calm - 1;
                else if ($urandom_range(0, 3) == 0)
                    take_stall <= pick_gap();
                else if ($urandom_range(0, 15) == 0)
                    take_calm <= $urandom_range(8, 30);
            end
        end
    end

    // Watchdog: end the run if neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;

        // Directed values: zero and one (not prime), two and three (no divisor
        // tried), perfect squares, products whose factor sits exactly at the
        // square root bound, a few known primes, alternating bit patterns,
        // and both ends of the field including the all-ones prime.
        values_to_send = '{
            value_t'(0),          value_t'(1),          value_t'(2),
            value_t'(3),          value_t'(4),          value_t'(5),
            value_t'(9),          value_t'(35),         value_t'(143),
            value_t'(63001),      value_t'(7919),       value_t'(65537),
            value_t'(1022117),    value_t'(1073741824), value_t'(1431655765),
            value_t'(715827882),  value_t'(2147483646), value_t'(VALUE_MAX)
        };

        // Random values: mostly low so the run stays short, some medium,
        // and some full-width composites built with a factor of 2 to 13 so
        // that the upper bits toggle without paying for a huge prime.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                raw_value = $urandom_range(0, 4095);
            else if (pick < 80)
                raw_value = $urandom_range(0, 65535);
            else if (pick < 90)
                raw_value = $urandom_range(0, 1048575);
            else
            begin
                factor    = $urandom_range(2, 13);
                raw_value = $urandom_range(1, VALUE_MAX / factor) * factor;
            end
            values_to_send.insert(values_to_send.size(), value_t'(raw_value));
        end
        items_total = values_to_send.size();

        // Hold reset, then release it on a rising edge.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every item is taken and every verdict has come back.
        while (items_taken < items_total || verdicts_due.size() != 0)
            @(posedge clk);

        // Linger a little to catch any stray output item.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
